// File: rtl/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream engine.
package cc20_pkg;

   // Default number of double rounds (RFC 8439 uses ten).
   localparam int DOUBLE_ROUNDS_DEF = 10;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int DATA_W      = 64;
   localparam int COUNT_W     = 4;
   localparam int POS_W       = 3;

   typedef logic [31:0]          word_type;
   typedef word_type [15:0]      state_type;

   // The four constant words "expand 32-byte k".
   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646e;
   localparam word_type SIGMA2 = 32'h79622d32;
   localparam word_type SIGMA3 = 32'h6b206574;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY0       = 3'd0,
      CSR_KEY1       = 3'd1,
      CSR_KEY2       = 3'd2,
      CSR_KEY3       = 3'd3,
      CSR_NONCE_LOW  = 3'd4,
      CSR_NONCE_HIGH = 3'd5,
      CSR_START_CTR  = 3'd6
   } csr_index_type;

   // Block generation sequencer states.
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_ROUND,
      CTL_ADD
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             accept;       // capture an input transaction
      logic             load_init;    // load the initial block state
      logic             round;        // run one column or diagonal round
      logic             diag;         // 1 selects the diagonal round
      logic             final_add;    // add the initial state back
      logic             emit;         // write the output register
      logic [POS_W-1:0] pos;          // keystream word in use
      logic             ctr_restart;  // reload the block counter
      logic             ctr_advance;  // step the block counter
   } dp_cmd_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } qr_type;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // One ChaCha quarter round.
   function automatic qr_type quarter(input word_type a, input word_type b,
                                      input word_type c, input word_type d);
      qr_type q;
      q.a = a;
      q.b = b;
      q.c = c;
      q.d = d;
      q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 16);
      q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 12);
      q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
      q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
      return q;
   endfunction

   // Four independent quarter rounds over the columns or the diagonals.
   function automatic state_type half_round(input state_type s, input logic diag);
      state_type r;
      qr_type    q;
      r = s;
      for (int c = 0; c < 4; c++) begin
         if (!diag) begin
            q = quarter(s[c], s[4 + c], s[8 + c], s[12 + c]);
            r[c]      = q.a;
            r[4 + c]  = q.b;
            r[8 + c]  = q.c;
            r[12 + c] = q.d;
         end else begin
            q = quarter(s[c], s[4 + ((c + 1) & 3)], s[8 + ((c + 2) & 3)],
                        s[12 + ((c + 3) & 3)]);
            r[c]                  = q.a;
            r[4 + ((c + 1) & 3)]  = q.b;
            r[8 + ((c + 2) & 3)]  = q.c;
            r[12 + ((c + 3) & 3)] = q.d;
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/chacha20_stream_xor.sv
// ChaCha20 stream engine: an accepted input transaction waits in the pending input register
// until its keystream block is ready and the output register is free. A new 64-byte block
// takes one load, one column or diagonal round per cycle, and one feed-forward add.
// Within a block one transaction per cycle passes while the receiver does not stall.
// A pending input register and an output register decouple the two channels.
// Synchronous active-high reset clears the control flags and configuration to zero.
module chacha20_stream_xor #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cc20_pkg::DATA_W-1:0]      req_data_in,
   input  logic [cc20_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic                             req_last_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cc20_pkg::DATA_W-1:0]      rsp_data_out,
   output logic                             rsp_last_out,
   input  logic                             csr_wr_en,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cc20_pkg::*;

   dp_cmd_type cmd;
   logic       item_last;

   cc20_ctrl #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .item_last   (item_last),
      .cmd         (cmd)
   );

   cc20_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_data_in    (req_data_in),
      .req_byte_count (req_byte_count),
      .req_last_in    (req_last_in),
      .cmd            (cmd),
      .item_last      (item_last),
      .rsp_data_out   (rsp_data_out),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

// File: rtl/cc20_ctrl.sv
// Controller: transaction handshakes, block sequencer and keystream position.
module cc20_ctrl #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             csr_wr_en,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                             item_last,
   output cc20_pkg::dp_cmd_type             cmd
);
   import cc20_pkg::*;

   localparam int ROUNDS     = 2 * DOUBLE_ROUNDS;
   localparam int RND_W      = $clog2(ROUNDS);
   localparam int ROUND_LAST = ROUNDS - 1;

   ctl_state_type    state_ff, state_in;
   logic [RND_W-1:0] round_ff, round_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             block_ready_ff, block_ready_in;
   logic             item_valid_ff, item_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             emit;
   logic             accept;
   logic             ctr_write;
   logic             round_done;

   // A result leaves when a pending item has keystream and the output slot frees up.
   assign emit = item_valid_ff && block_ready_ff && (state_ff == CTL_IDLE) &&
                 (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !item_valid_ff || emit;
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign ctr_write  = csr_wr_en && (csr_index == CSR_START_CTR);
   assign round_done = (round_ff == RND_W'(ROUND_LAST));

   // Next state of the block sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE:  if (item_valid_ff && !block_ready_ff) state_in = CTL_ROUND;
         CTL_ROUND: if (round_done) state_in = CTL_ADD;
         CTL_ADD:   state_in = CTL_IDLE;
         default:   state_in = CTL_IDLE;
      endcase
   end

   // Datapath commands decoded from the state.
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.emit        = emit;
      cmd.pos         = pos_ff;
      cmd.diag        = round_ff[0];
      cmd.ctr_restart = emit && item_last;
      cmd.ctr_advance = emit && !item_last && (pos_ff == '1);
      unique case (state_ff)
         CTL_IDLE:  cmd.load_init = item_valid_ff && !block_ready_ff;
         CTL_ROUND: cmd.round     = 1'b1;
         CTL_ADD:   cmd.final_add = 1'b1;
         default:   cmd.load_init = 1'b0;
      endcase
   end

   // Round counter, keystream position and handshake flags.
   always_comb begin
      round_in       = (state_ff == CTL_ROUND) ? round_ff + 1'b1 : '0;
      pos_in         = pos_ff;
      block_ready_in = block_ready_ff;
      if (state_ff == CTL_ADD) block_ready_in = 1'b1;
      if (emit) begin
         if (item_last) begin
            pos_in         = '0;
            block_ready_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == '1) block_ready_in = 1'b0;
         end
      end
      if (ctr_write) block_ready_in = 1'b0;
      item_valid_in = accept ? 1'b1 : (emit ? 1'b0 : item_valid_ff);
      rsp_valid_in  = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CTL_IDLE;
         round_ff       <= '0;
         pos_ff         <= '0;
         block_ready_ff <= 1'b0;
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_ff       <= round_in;
         pos_ff         <= pos_in;
         block_ready_ff <= block_ready_in;
         item_valid_ff  <= item_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/cc20_dp.sv
// Datapath: configuration registers, block state, round logic and output register.
module cc20_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [cc20_pkg::DATA_W-1:0]      req_data_in,
   input  logic [cc20_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic                             req_last_in,
   input  cc20_pkg::dp_cmd_type             cmd,
   output logic                             item_last,
   output logic [cc20_pkg::DATA_W-1:0]      rsp_data_out,
   output logic                             rsp_last_out
);
   import cc20_pkg::*;

   logic [63:0]        key_ff [4];
   logic [63:0]        key_in [4];
   logic [63:0]        nonce_low_ff, nonce_low_in;
   word_type           nonce_high_ff, nonce_high_in;
   word_type           start_ctr_ff, start_ctr_in;
   word_type           block_ctr_ff, block_ctr_in;
   state_type          w_ff, w_in;
   state_type          init;
   logic [DATA_W-1:0]  item_data_ff;
   logic [COUNT_W-1:0] item_count_ff;
   logic               item_last_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_last_ff;
   logic [DATA_W-1:0]  keystream;
   logic [DATA_W-1:0]  mask;

   // Configuration register writes.
   always_comb begin
      for (int i = 0; i < 4; i++) key_in[i] = key_ff[i];
      nonce_low_in  = nonce_low_ff;
      nonce_high_in = nonce_high_ff;
      start_ctr_in  = start_ctr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY0:       key_in[0]     = csr_wdata;
            CSR_KEY1:       key_in[1]     = csr_wdata;
            CSR_KEY2:       key_in[2]     = csr_wdata;
            CSR_KEY3:       key_in[3]     = csr_wdata;
            CSR_NONCE_LOW:  nonce_low_in  = csr_wdata;
            CSR_NONCE_HIGH: nonce_high_in = csr_wdata[31:0];
            CSR_START_CTR:  start_ctr_in  = csr_wdata[31:0];
            default:        nonce_low_in  = nonce_low_ff;
         endcase
      end
   end

   // Block counter: loaded by a start counter write or at a message end, stepped after a block's last word.
   always_comb begin
      block_ctr_in = block_ctr_ff;
      if (csr_wr_en && (csr_index == CSR_START_CTR)) block_ctr_in = csr_wdata[31:0];
      else if (cmd.ctr_restart)                      block_ctr_in = start_ctr_ff;
      else if (cmd.ctr_advance)                      block_ctr_in = block_ctr_ff + 1'b1;
   end

   // Initial block state from constants, key, counter and nonce.
   always_comb begin
      init[0]  = SIGMA0;
      init[1]  = SIGMA1;
      init[2]  = SIGMA2;
      init[3]  = SIGMA3;
      for (int i = 0; i < 4; i++) begin
         init[4 + 2*i] = key_ff[i][31:0];
         init[5 + 2*i] = key_ff[i][63:32];
      end
      init[12] = block_ctr_ff;
      init[13] = nonce_low_ff[31:0];
      init[14] = nonce_low_ff[63:32];
      init[15] = nonce_high_ff;
   end

   // Working state: load, one round per cycle, then the feed-forward add.
   always_comb begin
      w_in = w_ff;
      if (cmd.load_init) begin
         w_in = init;
      end else if (cmd.round) begin
         w_in = half_round(w_ff, cmd.diag);
      end else if (cmd.final_add) begin
         for (int i = 0; i < 16; i++) w_in[i] = w_ff[i] + init[i];
      end
   end

   // Keystream word selection and byte mask for the pending transaction.
   always_comb begin
      keystream = {w_ff[{cmd.pos, 1'b1}], w_ff[{cmd.pos, 1'b0}]};
      for (int i = 0; i < 8; i++) begin
         mask[8*i +: 8] = (COUNT_W'(i) < item_count_ff) ? 8'hff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         start_ctr_ff  <= '0;
         block_ctr_ff  <= '0;
      end else begin
         for (int i = 0; i < 4; i++) key_ff[i] <= key_in[i];
         nonce_low_ff  <= nonce_low_in;
         nonce_high_ff <= nonce_high_in;
         start_ctr_ff  <= start_ctr_in;
         block_ctr_ff  <= block_ctr_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      w_ff <= w_in;
      if (cmd.accept) begin
         item_data_ff  <= req_data_in;
         item_count_ff <= req_byte_count;
         item_last_ff  <= req_last_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= (item_data_ff ^ keystream) & mask;
         rsp_last_ff <= item_last_ff;
      end
   end

   assign item_last    = item_last_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

// File: rtl/cc20_checker.sv
// Port-level checker for the ChaCha20 stream engine, bound to the top level.
module cc20_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cc20_pkg::DATA_W-1:0] rsp_data_out,
   input logic                        rsp_last_out
);
   logic [1:0] outstanding_ff, outstanding_in;
   logic       in_fire;
   logic       out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;

   // Transactions accepted but not yet delivered.
   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_fire && !out_fire)      outstanding_in = outstanding_ff + 1'b1;
      else if (out_fire && !in_fire) outstanding_in = outstanding_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) outstanding_ff <= '0;
      else       outstanding_ff <= outstanding_in;
   end

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_last_out))
      else $error("result changed while stalled");

   // No result appears right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Every result belongs to an accepted transaction.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result without a pending transaction");

   // The engine holds at most two transactions.
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == 2'd2) && !rsp_ready |-> !req_ready)
      else $error("input accepted with both slots full");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (.*);

// File: verif/chacha20_stream_xor_tb.sv
// Self-checking testbench for the ChaCha20 stream XOR engine.
module chacha20_stream_xor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cc20_pkg::*;

   localparam int DOUBLE_ROUNDS  = DOUBLE_ROUNDS_DEF;
   localparam int SETTLE_CYCLES  = 2 * DOUBLE_ROUNDS + 10;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 135;
   localparam int DIRECTED_ROWS  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

   // One directed stimulus row; pinned rows carry an expected data_out typed in.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        pinned;
      logic [63:0] pinned_data;
   } stim_row_type;

   typedef struct packed {
      logic [63:0] data;
      logic        last;
   } cipher_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [DATA_W-1:0]      req_data_in = '0;
   logic [COUNT_W-1:0]     req_byte_count = '0;
   logic                   req_last_in = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DATA_W-1:0]      rsp_data_out;
   logic                   rsp_last_out;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_KEY0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the configuration and the keystream state.
   logic [63:0] key_reg [4];
   logic [63:0] nonce_lo_reg;
   logic [31:0] nonce_hi_reg;
   logic [31:0] ctr_start_reg;
   state_type   keystream;
   logic [2:0]  word_pos;
   logic [31:0] block_ctr;
   logic        block_valid;

   cipher_word_type expected_q [$];
   cipher_word_type oldest_word;
   cipher_word_type predicted_word;
   int unsigned     fail_count = 0;

   // Set by the sender along with the payload of a pinned directed row.
   logic        pin_flag = 1'b0;
   logic [63:0] pin_value = '0;

   int unsigned burst_left = 0;
   logic [15:0] ready_pattern = '1;
   int unsigned pattern_age = 0;

   chacha20_stream_xor #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rotate left by n using a doubled word.
   function automatic word_type rol32(word_type v, int unsigned n);
      logic [63:0] twice;
      twice = {v, v} << n;
      return twice[63:32];
   endfunction

   function automatic state_type mix_quarter(state_type s, int a, int b, int c, int d);
      s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
      return s;
   endfunction

   // Build the 64-byte keystream block for the current counter.
   function automatic state_type chacha_block();
      state_type init, w;
      init[0] = SIGMA0;
      init[1] = SIGMA1;
      init[2] = SIGMA2;
      init[3] = SIGMA3;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2 * k] = key_reg[k][31:0];
         init[5 + 2 * k] = key_reg[k][63:32];
      end
      init[12] = block_ctr;
      init[13] = nonce_lo_reg[31:0];
      init[14] = nonce_lo_reg[63:32];
      init[15] = nonce_hi_reg;
      w = init;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         w = mix_quarter(w, 0, 4, 8, 12);
         w = mix_quarter(w, 1, 5, 9, 13);
         w = mix_quarter(w, 2, 6, 10, 14);
         w = mix_quarter(w, 3, 7, 11, 15);
         w = mix_quarter(w, 0, 5, 10, 15);
         w = mix_quarter(w, 1, 6, 11, 12);
         w = mix_quarter(w, 2, 7, 8, 13);
         w = mix_quarter(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
         w[i] = w[i] + init[i];
      return w;
   endfunction

   function automatic void clear_model();
      for (int k = 0; k < 4; k++)
         key_reg[k] = '0;
      nonce_lo_reg  = '0;
      nonce_hi_reg  = '0;
      ctr_start_reg = '0;
      keystream     = '0;
      word_pos      = '0;
      block_ctr     = '0;
      block_valid   = 1'b0;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] value);
      case (idx)
         CSR_KEY0:       key_reg[0] = value;
         CSR_KEY1:       key_reg[1] = value;
         CSR_KEY2:       key_reg[2] = value;
         CSR_KEY3:       key_reg[3] = value;
         CSR_NONCE_LOW:  nonce_lo_reg = value;
         CSR_NONCE_HIGH: nonce_hi_reg = value[31:0];
         CSR_START_CTR: begin
            // A new start counter reloads the block counter and drops the block.
            ctr_start_reg = value[31:0];
            block_ctr     = value[31:0];
            block_valid   = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // XOR one message word with the next keystream word and advance the stream.
   function automatic cipher_word_type predict_cipher(logic [63:0] data, logic [3:0] count,
                                                      logic last);
      cipher_word_type res;
      logic [63:0] pad, keep;
      if (!block_valid) begin
         keystream   = chacha_block();
         block_valid = 1'b1;
      end
      pad = {keystream[2 * word_pos + 1], keystream[2 * word_pos]};
      for (int b = 0; b < 8; b++)
         keep[8 * b +: 8] = (b < count) ? 8'hFF : 8'h00;
      res.data = (data ^ pad) & keep;
      res.last = last;
      if (last) begin
         word_pos    = '0;
         block_ctr   = ctr_start_reg;
         block_valid = 1'b0;
      end else begin
         word_pos = word_pos + 3'd1;
         if (word_pos == 3'd0) begin
            block_ctr   = block_ctr + 32'd1;
            block_valid = 1'b0;
         end
      end
      return res;
   endfunction

   // Scoreboard: check result transactions, then track writes and accepted inputs.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction: data_out %h last_out %b",
                      rsp_data_out, rsp_last_out);
               fail_count++;
            end else begin
               oldest_word = expected_q.pop_front();
               if (rsp_data_out !== oldest_word.data) begin
                  $error("data_out mismatch: expected %h, got %h",
                         oldest_word.data, rsp_data_out);
                  fail_count++;
               end
               if (rsp_last_out !== oldest_word.last) begin
                  $error("last_out mismatch: expected %b, got %b",
                         oldest_word.last, rsp_last_out);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en)
            apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            predicted_word = predict_cipher(req_data_in, req_byte_count, req_last_in);
            if (pin_flag)
               predicted_word.data = pin_value;
            expected_q.push_back(predicted_word);
         end
      end
   end

   // Receiver stalls follow a rotating pattern that is reloaded now and then.
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= 16'($urandom & $urandom) | 16'h1;
            default: ready_pattern <= 16'($urandom) | 16'h1;
         endcase
         pattern_age <= $urandom_range(50, 300);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         pattern_age <= pattern_age - 1;
      end
      rsp_ready <= ready_pattern[0];
   end

   // Present one input transaction and wait until it is taken.
   task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                            input logic last, input logic pinned,
                            input logic [63:0] pinned_data);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_data_in    <= data;
      req_byte_count <= count;
      req_last_in    <= last;
      pin_flag  = pinned;
      pin_value = pinned_data;
      burst_left--;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 64'h0},
      '{ONES64,                  4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 4'd1,  1'b0, 1'b0, 64'h0},
      '{ONES64,                  4'd0,  1'b0, 1'b1, 64'h0},
      '{ONES64,                  4'd7,  1'b0, 1'b0, 64'h0},
      '{ONES64,                  4'd8,  1'b0, 1'b0, 64'h0},
      '{64'hFEDC_BA98_7654_3210, 4'd9,  1'b0, 1'b0, 64'h0},
      '{ONES64,                  4'd15, 1'b0, 1'b0, 64'h0},
      '{64'hDEAD_BEEF_CAFE_F00D, 4'd3,  1'b1, 1'b0, 64'h0},
      '{ONES64,                  4'd0,  1'b1, 1'b1, 64'h0},
      '{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b0, 64'h0},
      '{ONES64,                  4'd4,  1'b1, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h7FFF_FFFF_FFFF_FFFE, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h0F0F_0F0F_0F0F_0F0F, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'hF0F0_F0F0_F0F0_F0F0, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_FFFF_FFFF, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_0000_0000, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h1122_3344_5566_7788, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h99AA_BBCC_DDEE_FF00, 4'd8,  1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 64'h0},
      '{ONES64,                  4'd2,  1'b1, 1'b0, 64'h0}
   };

   // Main sequence: reset, directed table, then random phases under changing keys.
   initial begin : stimulus
      int unsigned msg_left;
      logic [3:0]  count;
      logic        last;

      msg_left = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed rows run under the reset configuration.
      foreach (directed_rows[i])
         send_word(directed_rows[i].data, directed_rows[i].count, directed_rows[i].last,
                   directed_rows[i].pinned, directed_rows[i].pinned_data);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         repeat (SETTLE_CYCLES) @(negedge clock);

         // Reconfigure while idle; a message may be left open across the write.
         case (phase % 4)
            0: begin
               write_csr(CSR_KEY0, ONES64);
               write_csr(CSR_KEY1, ONES64);
               write_csr(CSR_KEY2, ONES64);
               write_csr(CSR_KEY3, ONES64);
               write_csr(CSR_NONCE_LOW, ONES64);
               write_csr(CSR_NONCE_HIGH, ONES64);
               write_csr(CSR_START_CTR, ONES64);
            end
            1: begin
               write_csr(CSR_KEY0, {$urandom, $urandom});
               write_csr(CSR_KEY1, {$urandom, $urandom});
               write_csr(CSR_KEY2, {$urandom, $urandom});
               write_csr(CSR_KEY3, {$urandom, $urandom});
               write_csr(CSR_NONCE_LOW, {$urandom, $urandom});
               write_csr(CSR_NONCE_HIGH, {$urandom, $urandom});
               write_csr(CSR_START_CTR, {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))});
               write_csr(CSR_SPARE, {$urandom, $urandom});
            end
            2: begin
               write_csr(CSR_KEY0, '0);
               write_csr(CSR_KEY1, '0);
               write_csr(CSR_KEY2, '0);
               write_csr(CSR_KEY3, '0);
               write_csr(CSR_NONCE_LOW, '0);
               write_csr(CSR_NONCE_HIGH, '0);
               write_csr(CSR_START_CTR, '0);
            end
            default: begin
               // Rewrite a random subset of the registers.
               for (int idx = CSR_KEY0; idx <= CSR_START_CTR; idx++)
                  if ($urandom_range(0, 1) == 1)
                     write_csr(CSR_INDEX_W'(idx), {$urandom, $urandom});
               write_csr(CSR_SPARE, {$urandom, $urandom});
            end
         endcase

         // Mostly well-formed messages, with some noise transactions mixed in.
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) begin
               count = 4'($urandom_range(0, 15));
               last  = 1'($urandom_range(0, 1));
               if (last)
                  msg_left = 0;
            end else begin
               last  = (msg_left == 1);
               count = last ? 4'($urandom_range(1, 8)) : 4'd8;
               msg_left--;
            end
            send_word({$urandom, $urandom}, count, last, 1'b0, 64'h0);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
